/* sv/spa_pkg.sv */
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the sparse polynomial adder.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

	localparam int MAX_TERMS_DEF = 16;

	localparam int COEF_W = 16;
	localparam int SUM_W  = 17;
	localparam int EXP_W  = 8;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_MERGE       = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0]        exponent;
	} spa_in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_coefficient;
		logic [EXP_W-1:0]        term_exponent;
		logic                    final_term;
	} spa_out_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0]        exponent;
	} spa_term_t;

endpackage

`default_nettype wire

/* sv/spa_ram.sv */
// ----------------------------------------------------------------------------
// spa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/sparse_polynomial_adder_top.sv */
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_top
// Adds two sparse polynomials held as (coefficient, exponent) term lists.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid/cmd_ready/cmd): a load beat appends one term to
// the first or the second list; a load into a full list and the
// unused operation code are dropped. A merge beat walks both lists and emits
// the sum polynomial on the term channel (term_valid/term_ready/term), with
// final_term set on the last beat; both lists are then empty.
// Each result term takes a fetch step, which reads both term RAMs, and then a
// compare step, which compares exponents and adds. A merge of two empty lists
// emits nothing. cmd_ready is low for the whole merge.
// The single output register decouples the sides: a stalled receiver holds
// the walk at the compare step until the pending beat is taken, and the next
// command may be accepted while the final beat still waits.
// Reset clears both list counts, the sequencer and the output register; the
// term RAMs are not cleared, only entries below a list's count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_adder_top
	import spa_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_ready,
	input  wire spa_in_t cmd,
	output logic         term_valid,
	input  wire logic    term_ready,
	output spa_out_t     term
);

	localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int TERM_W = $bits(spa_term_t);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CMP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [CNT_W-1:0] ptr_a_q, ptr_b_q;
	logic             out_valid_q;
	spa_out_t         out_q;

	logic      cmd_fire;
	logic      we_a, we_b;
	logic      rd_en;
	logic      emit;
	spa_term_t wterm;
	spa_term_t rterm_a, rterm_b;

	logic              live_a, live_b;
	logic              take_a, take_b;
	logic [CNT_W-1:0]  nxt_a, nxt_b;
	logic              done;
	logic              slot_free;
	spa_out_t          res;
	logic signed [SUM_W-1:0] ext_a, ext_b;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd_valid && cmd_ready;
	assign term_valid = out_valid_q;
	assign term       = out_q;

	assign wterm = {cmd.coefficient, cmd.exponent};
	assign we_a  = cmd_fire && (cmd.operation == OP_LOAD_FIRST) && (cnt_a_q < CNT_MAX);
	assign we_b  = cmd_fire && (cmd.operation == OP_LOAD_SECOND) && (cnt_b_q < CNT_MAX);
	assign rd_en = (state_q == ST_FETCH);
	assign emit  = (state_q == ST_CMP) && slot_free;

	spa_ram #(
		.WIDTH  (TERM_W),
		.DEPTH  (MAX_TERMS),
		.ADDR_W (IDX_W)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[IDX_W-1:0]),
		.wdata (wterm),
		.re    (rd_en),
		.raddr (ptr_a_q[IDX_W-1:0]),
		.rdata (rterm_a)
	);

	spa_ram #(
		.WIDTH  (TERM_W),
		.DEPTH  (MAX_TERMS),
		.ADDR_W (IDX_W)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[IDX_W-1:0]),
		.wdata (wterm),
		.re    (rd_en),
		.raddr (ptr_b_q[IDX_W-1:0]),
		.rdata (rterm_b)
	);

	// shared compare and add step
	always_comb begin
		live_a = (ptr_a_q < cnt_a_q);
		live_b = (ptr_b_q < cnt_b_q);
		ext_a  = SUM_W'(rterm_a.coefficient);
		ext_b  = SUM_W'(rterm_b.coefficient);
		take_a = 1'b0;
		take_b = 1'b0;
		if (live_a && live_b) begin
			if (rterm_a.exponent == rterm_b.exponent) begin
				take_a = 1'b1;
				take_b = 1'b1;
			end else if (rterm_a.exponent > rterm_b.exponent) begin
				take_a = 1'b1;
			end else begin
				take_b = 1'b1;
			end
		end else if (live_a) begin
			take_a = 1'b1;
		end else begin
			take_b = 1'b1;
		end
		nxt_a = take_a ? ptr_a_q + CNT_W'(1) : ptr_a_q;
		nxt_b = take_b ? ptr_b_q + CNT_W'(1) : ptr_b_q;
		done  = (nxt_a >= cnt_a_q) && (nxt_b >= cnt_b_q);
		res.sum_coefficient = (take_a ? ext_a : '0) + (take_b ? ext_b : '0);
		res.term_exponent   = take_a ? rterm_a.exponent : rterm_b.exponent;
		res.final_term      = done;
		slot_free = !out_valid_q || term_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ptr_a_q     <= '0;
			ptr_b_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit) begin
				out_q       <= res;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && term_ready) begin
				out_valid_q <= 1'b0;
			end
			if (we_a) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					ptr_a_q <= '0;
					ptr_b_q <= '0;
					if (cmd_fire && (cmd.operation == OP_MERGE)) begin
						if ((cnt_a_q != '0) || (cnt_b_q != '0)) begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (emit) begin
						ptr_a_q <= nxt_a;
						ptr_b_q <= nxt_b;
						if (done) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
